// ===== hw/rtl/tga_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants for the TGA run-length pixel encoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  localparam int MaxRawDefault = 32;   // raw packet length limit
  localparam int RunLimit      = 128;  // longest run packet
  localparam int RunBias       = 127;  // run header is count plus this
  localparam int PixelWidth    = 32;

  // coder occupancy
  typedef enum logic [1:0] {
    MODE_EMPTY = 2'd0,
    MODE_ONE   = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_RAW   = 2'd3
  } mode_e;

  // sequencer
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FLUSH = 2'd1,
    ST_EMIT  = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic       has_header;
    logic [7:0] header_byte;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       packet_end;
    logic       last_result;
  } out_item_t;

endpackage

// ===== hw/rtl/tga_rle_ram.sv =====
// ----------------------------------------------------------------------------
// tga_rle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tga_rle_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/tga_rle_pixel_encoder_core.sv =====
// ----------------------------------------------------------------------------
// tga_rle_pixel_encoder_core
// Groups incoming RGBA pixels into TGA run-length packets.
// ----------------------------------------------------------------------------
// Input channel: one pixel per request (in_valid_i / in_stall_o), with
// last_pixel set on the final pixel of an image. Output channel: one pixel
// per request (out_valid_o / out_stall_i) in B,G,R,A order; the first pixel
// of a packet carries the packet header, packet_end marks its last pixel and
// last_result marks the final result caused by one input pixel.
// A pixel that only extends a run or a raw packet leaves the block ready
// again at once. A pixel that closes a packet holds the input off while the
// packet is sent: a raw packet is read back from the raw buffer RAM, one
// pixel per cycle through the single read port unless the receiver stalls,
// and a run packet is sent as its single pixel, plus one more packet of one
// pixel when last_pixel forces the final flush (at most MaxRaw + 1 results per pixel).
// Results sit in an output register; while the receiver stalls the sequencer
// waits on it and nothing is lost or repeated. Reset empties the coder and
// sets alpha_enable to 1. The raw buffer needs no clearing; entries are
// always written before they are read. The user writes alpha_enable through
// cfg_we_i / cfg_data_i only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module tga_rle_pixel_encoder_core #(
  parameter int MaxRaw = tga_rle_pkg::MaxRawDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tga_rle_pkg::in_item_t in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tga_rle_pkg::out_item_t out_item_o
);

  localparam int AddrW = $clog2(MaxRaw);
  localparam int CntW  = $clog2(MaxRaw + 1);
  localparam int PixW  = tga_rle_pkg::PixelWidth;

  tga_rle_pkg::state_e    state_q, state_d;
  tga_rle_pkg::mode_e     mode_q, mode_d;
  logic [PixW-1:0]        held_q, held_d;
  logic [7:0]             run_q, run_d;
  logic [CntW-1:0]        raw_q, raw_d;
  logic [AddrW-1:0]       idx_q, idx_d;
  logic [PixW-1:0]        px_q, px_d;
  logic                   last_q, last_d;
  logic                   final_q, final_d;
  logic                   alpha_en_q;
  logic                   out_valid_q, out_valid_d;
  tga_rle_pkg::out_item_t out_q, out_d;

  logic                   wr_en;
  logic [AddrW-1:0]       wr_addr;
  logic [PixW-1:0]        wr_data;
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic [PixW-1:0]        rd_data;

  logic                   out_free;
  logic [PixW-1:0]        in_px;
  logic                   in_eq;
  logic                   pre_flush;
  logic                   raw_first;
  logic                   raw_end;

  tga_rle_ram #(
    .Width(PixW),
    .Depth(MaxRaw)
  ) u_raw_buf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // pixel packed as alpha, blue, green, red from msb down
  assign in_px = {(alpha_en_q ? in_item_i.alpha : 8'hFF), in_item_i.blue,
                  in_item_i.green, in_item_i.red};
  assign in_eq = (in_px == held_q);

  assign raw_first = (idx_q == '0);
  assign raw_end   = ((CntW'(idx_q) + CntW'(1)) == raw_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    held_d      = held_q;
    run_d       = run_q;
    raw_d       = raw_q;
    idx_d       = idx_q;
    px_d        = px_q;
    last_d      = last_q;
    final_d     = final_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = raw_q[AddrW-1:0];
    wr_data     = in_px;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    pre_flush   = 1'b0;

    unique case (state_q)
      tga_rle_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          px_d   = in_px;
          last_d = in_item_i.last_pixel;
          unique case (mode_q)
            tga_rle_pkg::MODE_EMPTY: begin
              wr_en   = 1'b1;
              wr_addr = '0;
              held_d  = in_px;
              raw_d   = CntW'(1);
              run_d   = '0;
              mode_d  = tga_rle_pkg::MODE_ONE;
            end
            tga_rle_pkg::MODE_ONE: begin
              if (in_eq) begin
                mode_d = tga_rle_pkg::MODE_RUN;
                run_d  = 8'd2;
              end else begin
                wr_en  = 1'b1;
                raw_d  = raw_q + CntW'(1);
                held_d = in_px;
                mode_d = tga_rle_pkg::MODE_RAW;
              end
            end
            tga_rle_pkg::MODE_RUN: begin
              if (in_eq && (run_q < 8'(tga_rle_pkg::RunLimit))) begin
                run_d = run_q + 8'd1;
              end else begin
                pre_flush = 1'b1;
              end
            end
            tga_rle_pkg::MODE_RAW: begin
              if (!in_eq && (raw_q < CntW'(MaxRaw))) begin
                wr_en  = 1'b1;
                raw_d  = raw_q + CntW'(1);
                held_d = in_px;
              end else begin
                pre_flush = 1'b1;
              end
            end
            default: ;
          endcase
          idx_d = '0;
          if (pre_flush) begin
            state_d = tga_rle_pkg::ST_FLUSH;
            final_d = 1'b0;
          end else if (in_item_i.last_pixel) begin
            state_d = tga_rle_pkg::ST_FLUSH;
            final_d = 1'b1;
          end
        end
      end

      tga_rle_pkg::ST_FLUSH: begin
        if (mode_q == tga_rle_pkg::MODE_RUN) begin
          if (out_free) begin
            out_valid_d       = 1'b1;
            out_d.has_header  = 1'b1;
            out_d.header_byte = run_q + 8'(tga_rle_pkg::RunBias);
            out_d.out_blue    = held_q[23:16];
            out_d.out_green   = held_q[15:8];
            out_d.out_red     = held_q[7:0];
            out_d.out_alpha   = alpha_en_q ? held_q[31:24] : 8'hFF;
            out_d.packet_end  = 1'b1;
            out_d.last_result = final_q || !last_q;
            state_d           = tga_rle_pkg::ST_DONE;
          end
        end else begin
          // prime the read of the first buffered pixel
          rd_en   = 1'b1;
          state_d = tga_rle_pkg::ST_EMIT;
        end
      end

      tga_rle_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.has_header  = raw_first;
          out_d.header_byte = raw_first ? (8'(raw_q) - 8'd1) : 8'd0;
          out_d.out_blue    = rd_data[23:16];
          out_d.out_green   = rd_data[15:8];
          out_d.out_red     = rd_data[7:0];
          out_d.out_alpha   = alpha_en_q ? rd_data[31:24] : 8'hFF;
          out_d.packet_end  = raw_end;
          out_d.last_result = raw_end && (final_q || !last_q);
          if (raw_end) begin
            state_d = tga_rle_pkg::ST_DONE;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_q + AddrW'(1);
          end
        end
      end

      tga_rle_pkg::ST_DONE: begin
        mode_d = tga_rle_pkg::MODE_EMPTY;
        raw_d  = '0;
        run_d  = '0;
        idx_d  = '0;
        if (final_q) begin
          state_d = tga_rle_pkg::ST_IDLE;
        end else begin
          // the pixel that closed the packet opens a new one
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = px_q;
          held_d  = px_q;
          raw_d   = CntW'(1);
          mode_d  = tga_rle_pkg::MODE_ONE;
          if (last_q) begin
            state_d = tga_rle_pkg::ST_FLUSH;
            final_d = 1'b1;
          end else begin
            state_d = tga_rle_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = tga_rle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tga_rle_pkg::ST_IDLE;
      mode_q      <= tga_rle_pkg::MODE_EMPTY;
      held_q      <= '0;
      run_q       <= '0;
      raw_q       <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      final_q     <= 1'b0;
      alpha_en_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      held_q      <= held_d;
      run_q       <= run_d;
      raw_q       <= raw_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        alpha_en_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != tga_rle_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TGA run-length pixel encoder. Pixels go in
// through the request handshake and a scoreboard predicts the packet
// stream: run and raw packets, the header on the first pixel, the end and
// last-result marks, and alpha with the register set both ways. Both sides
// idle in random bursts, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MaxRaw   = tga_rle_pkg::MaxRawDefault;
  localparam int LongHold = 300;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef enum int {SHAPE_MIXED, SHAPE_RUN, SHAPE_RAW} image_shape_e;

  class rle_packet_checker;
    bit                     alpha_on = 1'b1;
    tga_rle_pkg::mode_e     mode     = tga_rle_pkg::MODE_EMPTY;
    rgba_t                  held     = '0;
    int unsigned            run_len  = 0;
    int unsigned            raw_len  = 0;
    rgba_t                  raw_buf [MaxRaw];
    tga_rle_pkg::out_item_t pending_q [$];
    int unsigned errors, pixels_in, results_seen, run_packets, raw_packets;

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("tb_top: mismatch: %s", msg);
    endtask

    function void queue_result(bit hdr, logic [7:0] hdr_byte, rgba_t px, bit pkt_end);
      tga_rle_pkg::out_item_t r;
      r.has_header  = hdr;
      r.header_byte = hdr ? hdr_byte : 8'd0;
      r.out_blue    = px.blue;
      r.out_green   = px.green;
      r.out_red     = px.red;
      r.out_alpha   = alpha_on ? px.alpha : 8'hff;
      r.packet_end  = pkt_end;
      r.last_result = 1'b0;
      pending_q.push_back(r);
    endfunction

    function void close_packet();
      int unsigned cnt;
      if (mode == tga_rle_pkg::MODE_RUN) begin
        queue_result(1'b1, 8'(run_len + tga_rle_pkg::RunBias), held, 1'b1);
      end else if (mode == tga_rle_pkg::MODE_ONE || mode == tga_rle_pkg::MODE_RAW) begin
        cnt = (raw_len > MaxRaw) ? MaxRaw : raw_len;
        for (int unsigned i = 0; i < cnt; i++) begin
          queue_result(i == 0, 8'(cnt - 1), raw_buf[i], i + 1 == cnt);
        end
      end
      mode    = tga_rle_pkg::MODE_EMPTY;
      raw_len = 0;
      run_len = 0;
    endfunction

    function void open_packet(rgba_t px);
      held       = px;
      raw_buf[0] = px;
      raw_len    = 1;
      run_len    = 0;
      mode       = tga_rle_pkg::MODE_ONE;
    endfunction

    // predicts every result that one accepted pixel causes
    function void take_pixel(tga_rle_pkg::in_item_t item);
      rgba_t                  px;
      tga_rle_pkg::out_item_t r;
      int unsigned            first_new;
      first_new = pending_q.size();
      pixels_in++;
      px.red   = item.red;
      px.green = item.green;
      px.blue  = item.blue;
      px.alpha = alpha_on ? item.alpha : 8'hff;
      case (mode)
        tga_rle_pkg::MODE_ONE: begin
          if (px == held) begin
            mode    = tga_rle_pkg::MODE_RUN;
            run_len = 2;
          end else begin
            if (raw_len < MaxRaw) begin
              raw_buf[raw_len] = px;
              raw_len++;
            end
            held = px;
            mode = tga_rle_pkg::MODE_RAW;
          end
        end
        tga_rle_pkg::MODE_RUN: begin
          if (px == held && run_len < tga_rle_pkg::RunLimit) begin
            run_len++;
          end else begin
            close_packet();
            open_packet(px);
          end
        end
        tga_rle_pkg::MODE_RAW: begin
          // an equal pixel closes the raw packet and starts a fresh one
          if (px != held && raw_len < MaxRaw) begin
            raw_buf[raw_len] = px;
            raw_len++;
            held = px;
          end else begin
            close_packet();
            open_packet(px);
          end
        end
        default: open_packet(px);
      endcase
      if (item.last_pixel) close_packet();
      if (pending_q.size() > first_new) begin
        r = pending_q.pop_back();
        r.last_result = 1'b1;
        pending_q.push_back(r);
      end
    endfunction

    task diff(string field, logic [7:0] got_v, logic [7:0] want_v);
      if (got_v !== want_v) begin
        report_mismatch($sformatf("result %0d %s got %h want %h",
                                  results_seen, field, got_v, want_v));
      end
    endtask

    task check_result(tga_rle_pkg::out_item_t got);
      tga_rle_pkg::out_item_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = pending_q.pop_front();
      if (want.has_header) begin
        if (want.header_byte >= 8'd128) run_packets++;
        else raw_packets++;
      end
      diff("has_header", 8'(got.has_header), 8'(want.has_header));
      diff("header_byte", got.header_byte, want.header_byte);
      diff("out_blue", got.out_blue, want.out_blue);
      diff("out_green", got.out_green, want.out_green);
      diff("out_red", got.out_red, want.out_red);
      diff("out_alpha", got.out_alpha, want.out_alpha);
      diff("packet_end", 8'(got.packet_end), 8'(want.packet_end));
      diff("last_result", 8'(got.last_result), 8'(want.last_result));
    endtask
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic                   cfg_data_i  = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  tga_rle_pkg::in_item_t  in_item_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  tga_rle_pkg::out_item_t out_item_o;

  bit          in_gaps_on    = 1'b0;
  bit          out_stalls_on = 1'b0;
  bit          hold_req      = 1'b0;
  int unsigned pixels_sent   = 0;

  rle_packet_checker sb;

  tga_rle_pixel_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // both channels sampled with the values from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_pixel(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    int unsigned hold_cycles;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < LongHold) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top: timeout with %0d results still expected", sb.pending_q.size());
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic tga_rle_pkg::in_item_t pix(logic [7:0] r, logic [7:0] g,
                                                logic [7:0] b, logic [7:0] a,
                                                logic last);
    tga_rle_pkg::in_item_t p;
    p.red        = r;
    p.green      = g;
    p.blue       = b;
    p.alpha      = a;
    p.last_pixel = last;
    return p;
  endfunction

  function automatic tga_rle_pkg::in_item_t rand_pixel();
    return pix(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
  endfunction

  task automatic push_pixel(input tga_rle_pkg::in_item_t item);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    // a pixel that only extends a packet may still be in flight
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_alpha(input bit on);
    in_valid_i <= 1'b0;
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= on;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.alpha_on = on;
  endtask

  task automatic send_image(input image_shape_e shape, input int unsigned len);
    tga_rle_pkg::in_item_t px;
    tga_rle_pkg::in_item_t prev;
    tga_rle_pkg::in_item_t palette [4];
    int unsigned           roll;
    foreach (palette[k]) palette[k] = rand_pixel();
    prev = rand_pixel();
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 9);
      case (shape)
        SHAPE_RUN: px = prev;
        SHAPE_RAW: begin
          px     = rand_pixel();
          px.red = prev.red + 8'd1;
        end
        default: begin
          if (roll < 4 && i > 0) begin
            px = prev;
          end else if (roll < 6) begin
            px = palette[$urandom_range(0, 3)];
          end else if (roll == 6) begin
            // same colour, alpha only differs
            px       = prev;
            px.alpha = 8'($urandom);
          end else begin
            px = rand_pixel();
          end
        end
      endcase
      px.last_pixel = (i + 1 == len) || ($urandom_range(0, 40) == 0);
      push_pixel(px);
      prev = px;
    end
  endtask

  initial begin
    int unsigned  phase_start;
    int unsigned  roll;
    image_shape_e shape;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone pixel, all bits low
    push_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
    // run of three, all bits high
    push_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
    push_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
    push_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
    // raw packet broken by a repeated pixel
    push_pixel(pix(8'h01, 8'h02, 8'h03, 8'h04, 1'b0));
    push_pixel(pix(8'h10, 8'h20, 8'h30, 8'h40, 1'b0));
    push_pixel(pix(8'h80, 8'h7f, 8'h01, 8'hfe, 1'b0));
    push_pixel(pix(8'h80, 8'h7f, 8'h01, 8'hfe, 1'b0));
    push_pixel(pix(8'h55, 8'haa, 8'h55, 8'haa, 1'b1));
    // run of two then a different last pixel
    push_pixel(pix(8'h12, 8'h34, 8'h56, 8'h78, 1'b0));
    push_pixel(pix(8'h12, 8'h34, 8'h56, 8'h78, 1'b0));
    push_pixel(pix(8'h9a, 8'hbc, 8'hde, 8'hf0, 1'b1));
    // alpha difference matters while alpha is on
    push_pixel(pix(8'h09, 8'h09, 8'h09, 8'h00, 1'b0));
    push_pixel(pix(8'h09, 8'h09, 8'h09, 8'h01, 1'b1));

    // with alpha off the same pixels form a run
    set_alpha(1'b0);
    push_pixel(pix(8'h09, 8'h09, 8'h09, 8'h00, 1'b0));
    push_pixel(pix(8'h09, 8'h09, 8'h09, 8'hff, 1'b0));
    push_pixel(pix(8'h09, 8'h09, 8'h09, 8'h07, 1'b1));

    // alpha switched off part way through a raw packet
    set_alpha(1'b1);
    push_pixel(pix(8'h01, 8'h01, 8'h01, 8'h11, 1'b0));
    push_pixel(pix(8'h02, 8'h02, 8'h02, 8'h22, 1'b0));
    set_alpha(1'b0);
    push_pixel(pix(8'h02, 8'h02, 8'h02, 8'h22, 1'b0));
    push_pixel(pix(8'h03, 8'h03, 8'h03, 8'h33, 1'b1));

    for (int p = 0; p < 6; p++) begin
      set_alpha((p % 2) == 0);
      in_gaps_on    = (p % 3) != 1 && p != 5;
      out_stalls_on = (p % 3) != 2 && p != 5;
      if (p == 2) hold_req = 1'b1;
      if (p == 0) begin
        // run past its limit, raw past its limit
        send_image(SHAPE_RUN, 130);
        send_image(SHAPE_RAW, 35);
      end
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < 25) begin
        roll = $urandom_range(0, 9);
        shape = (roll == 8) ? SHAPE_RUN : (roll == 9) ? SHAPE_RAW : SHAPE_MIXED;
        send_image(shape, $urandom_range(1, 24));
      end
    end
    in_valid_i <= 1'b0;
    drain();

    $display("tb_top: %0d pixels in, %0d results checked, %0d run and %0d raw packets",
             sb.pixels_in, sb.results_seen, sb.run_packets, sb.raw_packets);
    $display("tb_top: alpha on and off incl. mid-image, run and raw limits, %0d-cycle hold",
             LongHold);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
